@@ hdl/pst_pkg.sv @@
// ----------------------------------------------------------------------------
// pst_pkg
// shared constants and types for the priority schedule block
// ----------------------------------------------------------------------------
`default_nettype none
package pst_pkg;
  localparam int MAX_JOBS = 64;
  localparam int IDW = 6;
  localparam int CNTW = 7;
  localparam int BW = 16;
  localparam int PW = 8;
  localparam int TW = 22;
  localparam int SW = 36;
  localparam int AW = 30;
  localparam int QD = 4;
  localparam int QAW = 2;

  typedef struct packed {
    logic [IDW-1:0] id;
    logic [PW-1:0]  prio;
    logic [BW-1:0]  burst;
  } job_t;

  typedef struct packed {
    job_t job;
    logic last;
  } qword_t;

  typedef enum logic [2:0] {
    S_LOAD, S_SUM, S_DIV, S_EMIT, S_CLEAR
  } bstate_t;
endpackage
`default_nettype wire

@@ hdl/pst_front.sv @@
// ----------------------------------------------------------------------------
// pst_front
// numbers arriving jobs, drops jobs beyond capacity except the closing word, and queues the rest
// ----------------------------------------------------------------------------
`default_nettype none
module pst_front (
  input  wire              clk,
  input  wire              rst,
  input  wire              start,
  input  wire [15:0]       burst_time,
  input  wire [7:0]        job_priority,
  input  wire              last,
  input  wire              pop,
  output logic             q_valid,
  output pst_pkg::qword_t  q_word,
  output logic             q_full,
  output logic             ovf
);
  import pst_pkg::*;

  qword_t           mem [QD];
  logic [QAW:0]     fill;
  logic [QAW-1:0]   wp, rp;
  logic [CNTW-1:0]  count;
  logic             push, keep;

  assign q_full  = (fill >= (QAW+1)'(QD - 1)) ? 1'b1 : 1'b0;
  assign q_valid = (fill != '0);
  assign q_word  = mem[rp];
  assign push    = start && !q_full;
  assign keep    = (count < CNTW'(MAX_JOBS));

  always_ff @(posedge clk) begin
    if (push && (keep || last)) begin
      mem[wp] <= '{job: '{id: count[IDW-1:0], prio: job_priority, burst: burst_time},
                   last: last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      wp <= '0;
      rp <= '0;
      count <= '0;
      ovf <= 1'b0;
    end else begin
      if (push && (keep || last)) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      fill <= fill + (QAW+1)'(push && (keep || last)) - (QAW+1)'(pop);
      if (push) begin
        if (last) count <= '0;
        else if (keep) count <= count + 1'b1;
      end
      if (push && !keep && !last) ovf <= 1'b1;
      else if (pop && q_word.last) ovf <= 1'b0;
    end
  end
endmodule
`default_nettype wire

@@ hdl/pst_div.sv @@
// ----------------------------------------------------------------------------
// pst_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module pst_div (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     go,
  input  wire [pst_pkg::SW+7:0]   num,
  input  wire [pst_pkg::CNTW-1:0] den,
  output logic                    done,
  output logic [pst_pkg::AW-1:0]  quo
);
  import pst_pkg::*;

  logic [SW+7:0]   q;
  logic [CNTW:0]   r;
  logic [CNTW:0]   t;
  logic [5:0]      n;
  logic            run;

  assign t = {r[CNTW-1:0], q[SW+7]};
  assign quo = q[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      n <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        n <= 6'(SW + 8);
        q <= num;
        r <= '0;
      end else if (run) begin
        if (t >= {1'b0, den}) begin
          r <= t - {1'b0, den};
          q <= {q[SW+6:0], 1'b1};
        end else begin
          r <= t;
          q <= {q[SW+6:0], 1'b0};
        end
        n <= n - 1'b1;
        if (n == 6'd1) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ hdl/pst_back.sv @@
// ----------------------------------------------------------------------------
// pst_back
// keeps a priority-sorted chain, sums totals, divides and emits results
// ----------------------------------------------------------------------------
`default_nettype none
module pst_back (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    q_valid,
  input  pst_pkg::qword_t        q_word,
  input  wire                    ovf,
  output logic                   pop,
  output logic                   strobe,
  output logic [5:0]             job_id,
  output logic [7:0]             job_priority_out,
  output logic [15:0]            burst_out,
  output logic [21:0]            turnaround,
  output logic [21:0]            waiting,
  output logic                   end_of_batch,
  output logic [29:0]            avg_turnaround,
  output logic [29:0]            avg_waiting,
  output logic                   overflowed
);
  import pst_pkg::*;

  job_t            chain [MAX_JOBS];
  logic [MAX_JOBS-1:0] gt;
  logic [CNTW-1:0] n;
  logic [CNTW-1:0] idx;
  bstate_t         st, st_next;
  logic            ovf_b;
  logic [TW+1:0]   tat;
  logic [SW-1:0]   tot_t, tot_w;
  logic            dgo, ddone, dsel;
  logic [AW-1:0]   dq, avg_t, avg_w;
  logic [SW+7:0]   dnum;
  job_t            cur;

  always_comb begin
    for (int i = 0; i < MAX_JOBS; i++) begin
      gt[i] = (CNTW'(i) < n) && (chain[i].prio > q_word.job.prio);
    end
  end

  always_ff @(posedge clk) begin
    if (st == S_LOAD && q_valid && (n < CNTW'(MAX_JOBS))) begin
      for (int i = 0; i < MAX_JOBS; i++) begin
        if (gt[i]) begin
          if (i + 1 < MAX_JOBS) chain[i+1] <= chain[i];
        end else if (i == 0 || !gt[i-1]) begin
          if (CNTW'(i) == n) chain[i] <= q_word.job;
        end
        if (gt[i] && (i == 0 || !gt[i-1])) chain[i] <= q_word.job;
      end
    end else if (st == S_SUM && idx != n) begin
      // rotate the used part of the chain so the head walks every job
      for (int i = 0; i < MAX_JOBS; i++) begin
        if (CNTW'(i + 1) == n) chain[i] <= chain[0];
        else if (i + 1 < MAX_JOBS) chain[i] <= chain[i+1];
      end
    end else if (st == S_EMIT) begin
      for (int i = 0; i + 1 < MAX_JOBS; i++) chain[i] <= chain[i+1];
    end
  end

  assign cur  = chain[0];
  assign pop  = (st == S_LOAD) && q_valid;
  assign dnum = (st == S_DIV) ? {tot_w, 8'd0} : {tot_t, 8'd0};

  pst_div u_div (
    .clk(clk), .rst(rst), .go(dgo), .num(dnum), .den(n), .done(ddone), .quo(dq)
  );

  always_ff @(posedge clk) begin
    if (rst) st <= S_LOAD;
    else st <= st_next;
  end

  always_comb begin
    st_next = st;
    dgo = 1'b0;
    case (st)
      S_LOAD: if (q_valid && q_word.last) st_next = S_SUM;
      S_SUM: if (idx == n) begin
        st_next = S_DIV;
        dgo = 1'b1;
      end
      S_DIV: if (ddone) begin
        if (dsel) st_next = S_EMIT;
        else dgo = 1'b1;
      end
      S_EMIT: if (idx + 1'b1 == n) st_next = S_CLEAR;
      S_CLEAR: st_next = S_LOAD;
      default: st_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n <= '0;
      idx <= '0;
      strobe <= 1'b0;
      dsel <= 1'b0;
      ovf_b <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (st)
        S_LOAD: if (q_valid) begin
          if (n < CNTW'(MAX_JOBS)) n <= n + 1'b1;
          if (q_word.last) begin
            ovf_b <= ovf || (n >= CNTW'(MAX_JOBS));
            idx <= '0;
            tat <= '0;
            tot_t <= '0;
            tot_w <= '0;
          end
        end
        S_SUM: if (idx != n) begin
          tat <= tat + (TW+2)'(cur.burst);
          tot_t <= tot_t + SW'(tat) + SW'(cur.burst);
          tot_w <= tot_w + SW'(tat);
          idx <= idx + 1'b1;
        end else begin
          idx <= '0;
          tat <= '0;
          dsel <= 1'b0;
        end
        S_DIV: if (ddone) begin
          if (!dsel) begin
            avg_t <= dq;
            dsel <= 1'b1;
          end else begin
            avg_w <= dq;
          end
        end
        S_EMIT: begin
          strobe <= 1'b1;
          job_id <= cur.id;
          job_priority_out <= cur.prio;
          burst_out <= cur.burst;
          turnaround <= TW'(tat + (TW+2)'(cur.burst));
          waiting <= TW'(tat);
          tat <= tat + (TW+2)'(cur.burst);
          overflowed <= ovf_b;
          end_of_batch <= (idx + 1'b1 == n);
          avg_turnaround <= (idx + 1'b1 == n) ? avg_t : '0;
          avg_waiting <= (idx + 1'b1 == n) ? avg_w : '0;
          idx <= idx + 1'b1;
        end
        S_CLEAR: begin
          n <= '0;
          dsel <= 1'b0;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ hdl/priority_schedule_times.sv @@
// ----------------------------------------------------------------------------
// priority_schedule_times
// non-preemptive priority scheduler for one batch of jobs
// ----------------------------------------------------------------------------
// a job word is taken when start is high and busy is low; the word with
// last set closes the batch. jobs beyond 64 are dropped and flagged.
// while loading, one word per cycle is taken and inserted into a
// priority-sorted chain; busy rises once the queue holds three words.
// after the last word of n jobs the back end inserts it, sums the chain,
// runs two serial divides for the averages, then drives one result per
// cycle on the strobe, in sorted order, stable on equal priority. after the
// last result the back end passes through a clear state before the next
// batch is loaded. the receiver cannot stall; results are lost if not taken.
// a short queue lets the front take words while the back works.
// reset clears the queue, the counters and the control state.
// ----------------------------------------------------------------------------
`default_nettype none
module priority_schedule_times (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  output logic        busy,
  input  wire [15:0]  burst_time,
  input  wire [7:0]   job_priority,
  input  wire         last,
  output logic        strobe,
  output logic [5:0]  job_id,
  output logic [7:0]  job_priority_out,
  output logic [15:0] burst_out,
  output logic [21:0] turnaround,
  output logic [21:0] waiting,
  output logic        end_of_batch,
  output logic [29:0] avg_turnaround,
  output logic [29:0] avg_waiting,
  output logic        overflowed
);
  import pst_pkg::*;

  qword_t q_word;
  logic   q_valid, q_full, ovf, pop;

  assign busy = q_full;

  pst_front u_front (
    .clk(clk), .rst(rst), .start(start & ~busy), .burst_time(burst_time),
    .job_priority(job_priority), .last(last), .pop(pop),
    .q_valid(q_valid), .q_word(q_word), .q_full(q_full), .ovf(ovf)
  );

  pst_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_word(q_word), .ovf(ovf),
    .pop(pop), .strobe(strobe), .job_id(job_id),
    .job_priority_out(job_priority_out), .burst_out(burst_out),
    .turnaround(turnaround), .waiting(waiting), .end_of_batch(end_of_batch),
    .avg_turnaround(avg_turnaround), .avg_waiting(avg_waiting),
    .overflowed(overflowed)
  );
endmodule
`default_nettype wire

@@ hdl/pst_checker.sv @@
// ----------------------------------------------------------------------------
// pst_checker
// port-level checks for the priority schedule block
// ----------------------------------------------------------------------------
`default_nettype none
module pst_checker (
  input wire        clk,
  input wire        rst,
  input wire        strobe,
  input wire        end_of_batch,
  input wire [21:0] turnaround,
  input wire [21:0] waiting,
  input wire [15:0] burst_out
);
  a_wait: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (turnaround == 22'(waiting + 22'(burst_out))))
    else $error("waiting mismatch");
  a_chain: assert property (@(posedge clk) disable iff (rst)
    (strobe && !end_of_batch) ##1 strobe |-> waiting == $past(turnaround))
    else $error("turnaround chain broken");
  a_gap: assert property (@(posedge clk) disable iff (rst)
    (strobe && !end_of_batch) |=> strobe)
    else $error("result gap inside batch");
endmodule

bind priority_schedule_times pst_checker u_chk (
  .clk(clk), .rst(rst), .strobe(strobe), .end_of_batch(end_of_batch),
  .turnaround(turnaround), .waiting(waiting), .burst_out(burst_out)
);
`default_nettype wire

@@ bench/tb_priority_schedule_times.sv @@
// ----------------------------------------------------------------------------
// tb_priority_schedule_times
// self-checking bench for the priority schedule block
// ----------------------------------------------------------------------------
// job words are queued by a stimulus process and driven on start/busy by a
// clocked driver. batches are scheduled in the bench as they are sent (stable
// sort by priority, running turnaround and waiting, truncated 22.8 averages,
// drop and flag past 64 jobs) and every strobed result is checked in order.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_priority_schedule_times;
  import pst_pkg::*;

  typedef struct {
    logic [15:0] burst;
    logic [7:0]  prio;
    logic        last;
    logic        hold;   // wait for all results before sending
  } word_t;

  typedef struct {
    logic [5:0]  id;
    logic [7:0]  prio;
    logic [15:0] burst;
    logic [21:0] tat;
    logic [21:0] wt;
    logic        eob;
    logic [29:0] avg_tat;
    logic [29:0] avg_wt;
    logic        ovf;
  } sched_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [15:0] burst_time = '0;
  logic [7:0] job_priority = '0;
  logic last = 1'b0;
  wire busy, strobe, end_of_batch, overflowed;
  wire [5:0] job_id;
  wire [7:0] job_priority_out;
  wire [15:0] burst_out;
  wire [21:0] turnaround, waiting;
  wire [29:0] avg_turnaround, avg_waiting;

  priority_schedule_times dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .burst_time(burst_time), .job_priority(job_priority), .last(last),
    .strobe(strobe), .job_id(job_id), .job_priority_out(job_priority_out),
    .burst_out(burst_out), .turnaround(turnaround), .waiting(waiting),
    .end_of_batch(end_of_batch), .avg_turnaround(avg_turnaround),
    .avg_waiting(avg_waiting), .overflowed(overflowed)
  );

  always #1 clk = ~clk;

  word_t pending_words[$];
  sched_t expected_sched[$];
  job_t batch_jobs[$];
  logic batch_ovf = 1'b0;
  int errors = 0;
  int stall_pct = 6;
  int watchdog = 0;
  logic feed_done = 1'b0;
  logic taken = 1'b0;

  // schedule one batch when its closing word is accepted
  task automatic schedule_batch();
    job_t sorted[$];
    job_t v;
    int k, n;
    logic [63:0] tat, tot_tat, tot_wt;
    sched_t r;
    sorted = batch_jobs;
    n = sorted.size();
    for (int i = 1; i < n; i++) begin
      v = sorted[i];
      k = i;
      while (k > 0 && sorted[k-1].prio > v.prio) begin
        sorted[k] = sorted[k-1];
        k--;
      end
      sorted[k] = v;
    end
    tat = 0; tot_tat = 0; tot_wt = 0;
    for (int i = 0; i < n; i++) begin
      tat += sorted[i].burst;
      tot_tat += tat;
      tot_wt += tat - sorted[i].burst;
    end
    tat = 0;
    for (int i = 0; i < n; i++) begin
      tat += sorted[i].burst;
      r.id = sorted[i].id;
      r.prio = sorted[i].prio;
      r.burst = sorted[i].burst;
      r.tat = tat[21:0];
      r.wt = tat[21:0] - sorted[i].burst;
      r.eob = (i == n - 1);
      r.avg_tat = r.eob ? 30'((tot_tat * 256) / n) : '0;
      r.avg_wt = r.eob ? 30'((tot_wt * 256) / n) : '0;
      r.ovf = batch_ovf;
      expected_sched.push_back(r);
    end
    batch_jobs.delete();
    batch_ovf = 1'b0;
  endtask

  task automatic accept_word(word_t w);
    job_t j;
    if (batch_jobs.size() < MAX_JOBS) begin
      j.id = 6'(batch_jobs.size());
      j.prio = w.prio;
      j.burst = w.burst;
      batch_jobs.push_back(j);
    end else begin
      batch_ovf = 1'b1;
    end
    if (w.last) schedule_batch();
  endtask

  task automatic add_word(int b, int p, bit l, bit h = 0);
    word_t w;
    w.burst = 16'(b); w.prio = 8'(p); w.last = l; w.hold = h;
    pending_words.push_back(w);
  endtask

  task automatic add_batch(int n, int pmax, int bmax);
    for (int i = 0; i < n; i++)
      add_word($urandom_range(bmax, 0), $urandom_range(pmax, 0), i == n - 1);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && taken) begin
      // word taken at the last rising edge; pick the next one
      if (pending_words.size() > 0 && $urandom_range(99, 0) >= stall_pct &&
          !(pending_words[0].hold && expected_sched.size() > 0)) begin
        burst_time <= pending_words[0].burst;
        job_priority <= pending_words[0].prio;
        last <= pending_words[0].last;
        void'(pending_words.pop_front());
      end else begin
        start <= 1'b0;
      end
    end else if (!start && pending_words.size() > 0 &&
                 $urandom_range(99, 0) >= stall_pct &&
                 !(pending_words[0].hold && expected_sched.size() > 0)) begin
      start <= 1'b1;
      burst_time <= pending_words[0].burst;
      job_priority <= pending_words[0].prio;
      last <= pending_words[0].last;
      void'(pending_words.pop_front());
    end
  end

  // monitor
  always @(posedge clk) begin
    sched_t e;
    taken <= !rst && start && !busy;
    if (!rst) begin
      watchdog <= ((start && !busy) || strobe) ? 0 : watchdog + 1;
      if (start && !busy) begin
        word_t w;
        w.burst = burst_time; w.prio = job_priority; w.last = last; w.hold = 0;
        accept_word(w);
      end
      if (strobe) begin
        if (expected_sched.size() == 0) begin
          $display("%0t: unexpected word id=%0d", $realtime, job_id);
          errors++;
        end else begin
          e = expected_sched.pop_front();
          if ({job_id, job_priority_out, burst_out, turnaround, waiting, end_of_batch,
               avg_turnaround, avg_waiting, overflowed} !==
              {e.id, e.prio, e.burst, e.tat, e.wt, e.eob, e.avg_tat, e.avg_wt, e.ovf}) begin
            $display("%0t: mismatch exp id=%0d pr=%0d b=%0d tat=%0d wt=%0d eob=%0d",
                     $realtime, e.id, e.prio, e.burst, e.tat, e.wt, e.eob);
            $display("%0t:   exp avg_tat=%0d avg_wt=%0d ovf=%0d", $realtime,
                     e.avg_tat, e.avg_wt, e.ovf);
            $display("%0t:   act id=%0d pr=%0d b=%0d tat=%0d wt=%0d eob=%0d",
                     $realtime, job_id, job_priority_out, burst_out, turnaround,
                     waiting, end_of_batch);
            $display("%0t:   act avg_tat=%0d avg_wt=%0d ovf=%0d", $realtime,
                     avg_turnaround, avg_waiting, overflowed);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    int n;
    // directed: single job, extremes, ties, both field extremes
    add_word(16'hFFFF, 8'hFF, 1);
    add_word(0, 0, 1);
    add_word(5, 3, 0); add_word(7, 3, 0); add_word(1, 0, 0); add_word(9, 3, 1);
    add_word(16'hFFFF, 8'hFF, 0); add_word(16'hFFFF, 0, 0);
    add_word(16'h5555, 8'hAA, 0); add_word(16'hAAAA, 8'h55, 1);
    add_word(3, 200, 0); add_word(2, 100, 0); add_word(0, 50, 1, 1);
    add_word(12, 1, 0); add_word(12, 1, 0); add_word(12, 1, 1);
    // capacity: 66 jobs, last one dropped too, all bursts max
    for (int i = 0; i < 66; i++) add_word(16'hFFFF, $urandom_range(255, 0), i == 65, i == 0);
    // random batches, mostly small
    stall_pct = 6;
    repeat (5) begin
      n = ($urandom_range(9, 0) == 0) ? $urandom_range(12, 8) : $urandom_range(6, 1);
      add_batch(n, ($urandom_range(1, 0) ? 255 : 3), 65535);
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // stretch with no idling midway through
    wait (pending_words.size() < 80);
    stall_pct = 0;
    wait (pending_words.size() < 30);
    stall_pct = 6;
    wait (pending_words.size() == 0 && !(start && !busy));
    feed_done = 1'b1;
  end

  initial begin
    wait (feed_done && expected_sched.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_sched.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    wait (watchdog >= 20000);
    $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire
